[rtl/ptts_pkg.sv]
// Shared types and constants of the periodic task timer scheduler.
package ptts_pkg;

  localparam int CMD_W       = 2;
  localparam int DELAY_W     = 24;
  localparam int PERIOD_W    = 24;
  localparam int SLOT_W      = 5;
  localparam int KIND_W      = 3;
  localparam int TICK_W      = 21;
  localparam int PROD_W      = 48;
  localparam int DIV_SHIFT   = 27;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 6;

  // ceil(2^27 / 10): exact quotient by the 10 ms tick for any 24-bit value
  localparam logic [DELAY_W-1:0] TICK_RECIP = 24'd13421773;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_EMPTY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;

  typedef struct packed {
    logic cap;
    logic set_full;
    logic mul_dly;
    logic mul_per;
    logic add_wr;
    logic del_do;
    logic scan_start;
    logic eval;
    logic flush;
  } ptts_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd_code;
    logic             full;
    logic             fire;
    logic             pend;
    logic             out_free;
    logic             scan_last;
  } ptts_sts_t;

endpackage

[rtl/ptts_if.sv]
// Request and result channel interfaces of the periodic task timer scheduler.
interface ptts_in_if;
  import ptts_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [DELAY_W-1:0]  delay_ms;
  logic [PERIOD_W-1:0] period_ms;
  logic [SLOT_W-1:0]   slot;

  modport source(output valid, cmd, delay_ms, period_ms, slot, input ready);
  modport sink(input valid, cmd, delay_ms, period_ms, slot, output ready);
endinterface

interface ptts_out_if;
  import ptts_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] task_id;
  logic              last;

  modport source(output valid, kind, task_id, last, input ready);
  modport sink(input valid, kind, task_id, last, output ready);
endinterface

[rtl/ptts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ptts_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/ptts_ctrl.sv]
// Controller state machine of the periodic task timer scheduler.
module ptts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptts_pkg::ptts_sts_t sts,
  output ptts_pkg::ptts_cmd_t cmd
);
  import ptts_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL_P  = 3'd2;
  localparam logic [2:0] S_ADD_WR = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       stall;

  assign stall = sts.fire & sts.pend & ~sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd_code)
          CMD_ADD: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_EMIT;
            end else begin
              cmd.mul_dly = 1'b1;
              state_nxt   = S_MUL_P;
            end
          end
          CMD_DEL: begin
            cmd.del_do = 1'b1;
            state_nxt  = S_EMIT;
          end
          CMD_TICK: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MUL_P: begin
        cmd.mul_per = 1'b1;
        state_nxt   = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_SCAN: begin
        if (!stall) begin
          cmd.eval = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!sts.pend) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/ptts_dp.sv]
// Datapath of the periodic task timer scheduler: slot tables, divider, result registers.
module ptts_dp #(
  parameter int TASK_SLOTS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptts_pkg::ptts_cmd_t             cmd,
  output ptts_pkg::ptts_sts_t             sts,
  input  logic [ptts_pkg::CMD_W-1:0]      in_cmd,
  input  logic [ptts_pkg::DELAY_W-1:0]    in_delay_ms,
  input  logic [ptts_pkg::PERIOD_W-1:0]   in_period_ms,
  input  logic [ptts_pkg::SLOT_W-1:0]     in_slot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptts_pkg::KIND_W-1:0]     out_kind,
  output logic [ptts_pkg::SLOT_W-1:0]     out_task_id,
  output logic                            out_last
);
  import ptts_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic [CMD_W-1:0]    cmd_r;
  logic [DELAY_W-1:0]  delay_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PROD_W-1:0]   prod_r;
  logic [TICK_W-1:0]   dq_r;

  logic [TASK_SLOTS-1:0] active_r, active_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic                  pend_r, pend_nxt;
  logic [KIND_W-1:0]     res_kind_r, res_kind_nxt;
  logic [SLOT_W-1:0]     res_id_r, res_id_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]     out_kind_r;
  logic [SLOT_W-1:0]     out_id_r;
  logic                  out_last_r;

  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic             del_ok;
  logic             slot_act;
  logic             due;
  logic             fire;
  logic             scan_last;
  logic             out_free;
  logic             push;
  logic             push_last;

  logic              tk_we;
  logic [IDX_W-1:0]  tk_waddr;
  logic [TICK_W-1:0] tk_wdata;
  logic [TICK_W-1:0] tk_rdata;
  logic [TICK_W-1:0] rl_rdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign del_ok    = (32'(slot_r) < TASK_SLOTS) && active_r[IDX_W'(slot_r)];
  assign slot_act  = active_r[idx_r];
  assign due       = tk_rdata <= TICK_W'(1);
  assign fire      = slot_act & due & (n_r < CNT_W'(MAX_RESULTS));
  assign scan_last = idx_r == IDX_W'(TASK_SLOTS - 1);
  assign out_free  = ~out_valid_r | out_ready;

  assign rd_en    = cmd.scan_start | (cmd.eval & ~scan_last);
  assign rd_addr  = cmd.scan_start ? '0 : idx_r + IDX_W'(1);
  assign tk_we    = cmd.add_wr | (cmd.eval & slot_act);
  assign tk_waddr = cmd.add_wr ? free_idx : idx_r;

  always_comb begin
    if (cmd.add_wr) begin
      tk_wdata = dq_r;
    end else if (!due) begin
      tk_wdata = tk_rdata - TICK_W'(1);
    end else if (fire) begin
      tk_wdata = rl_rdata;
    end else begin
      tk_wdata = '0;
    end
  end

  ptts_ram #(.WIDTH(TICK_W), .DEPTH(TASK_SLOTS)) u_ticks_ram (
    .clk     (clk),
    .wr_en   (tk_we),
    .wr_addr (tk_waddr),
    .wr_data (tk_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (tk_rdata)
  );

  ptts_ram #(.WIDTH(TICK_W), .DEPTH(TASK_SLOTS)) u_reload_ram (
    .clk     (clk),
    .wr_en   (cmd.add_wr),
    .wr_addr (free_idx),
    .wr_data (prod_r[DIV_SHIFT +: TICK_W]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rl_rdata)
  );

  always_comb begin
    active_nxt   = active_r;
    pend_nxt     = pend_r;
    res_kind_nxt = res_kind_r;
    res_id_nxt   = res_id_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    push         = 1'b0;
    push_last    = 1'b0;
    if (cmd.set_full) begin
      pend_nxt     = 1'b1;
      res_kind_nxt = KIND_FULL;
      res_id_nxt   = '0;
    end
    if (cmd.add_wr) begin
      active_nxt[free_idx] = 1'b1;
      pend_nxt             = 1'b1;
      res_kind_nxt         = KIND_ADDED;
      res_id_nxt           = SLOT_W'(free_idx);
    end
    if (cmd.del_do) begin
      if (del_ok) begin
        active_nxt[IDX_W'(slot_r)] = 1'b0;
      end
      pend_nxt     = 1'b1;
      res_kind_nxt = del_ok ? KIND_DELETED : KIND_DEL_EMPTY;
      res_id_nxt   = slot_r;
    end
    if (cmd.scan_start) begin
      idx_nxt = '0;
      n_nxt   = '0;
    end
    if (cmd.eval) begin
      if (!scan_last) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (fire) begin
        push         = pend_r;
        n_nxt        = n_r + CNT_W'(1);
        pend_nxt     = 1'b1;
        res_kind_nxt = KIND_FIRED;
        res_id_nxt   = SLOT_W'(idx_r);
        if (rl_rdata == '0) begin
          active_nxt[idx_r] = 1'b0;
        end
      end
    end
    if (cmd.flush) begin
      push      = 1'b1;
      push_last = 1'b1;
      pend_nxt  = 1'b0;
    end
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
    end else begin
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    if (cmd.cap) begin
      cmd_r    <= in_cmd;
      delay_r  <= in_delay_ms;
      period_r <= in_period_ms;
      slot_r   <= in_slot;
    end
    if (cmd.mul_dly) begin
      prod_r <= delay_r * TICK_RECIP;
    end
    if (cmd.mul_per) begin
      dq_r   <= prod_r[DIV_SHIFT +: TICK_W];
      prod_r <= period_r * TICK_RECIP;
    end
    if (push) begin
      out_kind_r <= res_kind_r;
      out_id_r   <= res_id_r;
      out_last_r <= push_last;
    end
  end

  assign sts.cmd_code  = cmd_r;
  assign sts.full      = ~found;
  assign sts.fire      = fire;
  assign sts.pend      = pend_r;
  assign sts.out_free  = out_free;
  assign sts.scan_last = scan_last;

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_task_id = out_id_r;
  assign out_last    = out_last_r;

endmodule

[rtl/periodic_task_timer_scheduler_top.sv]
// Add: capture, decode with the delay multiply, period multiply, table write, emit.
// Delete: capture, decode, emit. Tick: one slot a cycle through the tick-count RAM read
// port, held while a firing or the final result waits on a stalled result register.
// One request at a time; the next is taken once the last result is queued.
// Reset clears the slot-active bits and control state; a slot's counters are
// written when it is added, so the tables need no clearing pass.
module periodic_task_timer_scheduler_top #(
  parameter int TASK_SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ptts_in_if.sink   in_ch,
  ptts_out_if.source out_ch
);
  import ptts_pkg::*;

  ptts_cmd_t ctl_cmd;
  ptts_sts_t dp_sts;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  ptts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (ctl_cmd),
    .sts          (dp_sts),
    .in_cmd       (in_ch.cmd),
    .in_delay_ms  (in_ch.delay_ms),
    .in_period_ms (in_ch.period_ms),
    .in_slot      (in_ch.slot),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_task_id  (out_ch.task_id),
    .out_last     (out_ch.last)
  );

`ifndef ASSERT_OFF
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while the previous one is in flight");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !dp_sts.pend)
    else $error("result still pending while idle");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ctl_cmd))
    else $error("more than one datapath command at once");
`endif

endmodule
